[rtl/core/sfr_pkg.sv]
// Shared constants, types and helpers for the stereo FDN reverb.
package sfr_pkg;

   localparam int SAMPLE_BITS   = 24;
   localparam int LINES         = 8;
   localparam int LINE_W        = $clog2(LINES);
   localparam int MAX_DELAY     = 4096;
   localparam int ADDR_W        = $clog2(MAX_DELAY);
   localparam int DLY_W         = 16;
   localparam int HAD_W         = SAMPLE_BITS + LINE_W;
   localparam int SUM_W         = SAMPLE_BITS + 2;
   localparam int WIDE_W        = 30;
   localparam int GAIN_W        = 16;
   localparam int COEF_W        = 17;
   localparam int CSR_IDX_W     = 8;
   localparam int CSR_DATA_W    = 64;
   localparam int INV_SQRT8_Q16 = 23170;
   localparam int FB_MAX        = 65405;
   localparam int ABS_MIN       = 655;
   localparam int UNITY_Q16     = 65536;
   localparam int WET_MIN       = 66;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [HAD_W-1:0]       had_type;
   typedef logic signed [SUM_W-1:0]       sum_type;

   // register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DELAYS_LOW  = 8'd0,
      CSR_DELAYS_HIGH = 8'd1,
      CSR_FEEDBACK    = 8'd2,
      CSR_ABSORB      = 8'd3,
      CSR_WET         = 8'd4,
      CSR_MONO        = 8'd5
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD, ST_ABS_MUL, ST_ABS_UPD, ST_HLOAD, ST_HB0, ST_HB1, ST_HB2,
      ST_SCALE, ST_GAIN, ST_WRITE, ST_OUTP
   } fsm_type;

   // sequencer strobes shared by the lanes and the merge stage
   typedef struct packed {
      logic             rd;
      logic             abs_mul;
      logic             abs_upd;
      logic             had_load;
      logic             had_step;
      logic [LINE_W-1:0] had_mask;
      logic             scale;
      logic             gain;
      logic             write;
   } lane_ctrl_type;

   // clamp to the signed sample range
   function automatic sample_type sat_sample(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
      lo = -hi - WIDE_W'(1);
      if (v > hi) return SAMPLE_BITS'(hi);
      else if (v < lo) return SAMPLE_BITS'(lo);
      else return SAMPLE_BITS'(v);
   endfunction

endpackage

[rtl/core/sfr_if.sv]
// Valid/ready channel interfaces for samples, results and register writes.
interface sfr_req_if;
   logic                        valid;
   logic                        ready;
   logic signed [sfr_pkg::SAMPLE_BITS-1:0] in_left;
   logic signed [sfr_pkg::SAMPLE_BITS-1:0] in_right;
   modport source (output valid, output in_left, output in_right, input ready);
   modport sink   (input valid, input in_left, input in_right, output ready);
endinterface

interface sfr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic signed [sfr_pkg::SAMPLE_BITS-1:0] out_left;
   logic signed [sfr_pkg::SAMPLE_BITS-1:0] out_right;
   modport source (output valid, output out_left, output out_right, input ready);
   modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

interface sfr_csr_if;
   logic                             valid;
   logic                             ready;
   logic [sfr_pkg::CSR_IDX_W-1:0]    index;
   logic [sfr_pkg::CSR_DATA_W-1:0]   data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/sfr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sfr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/core/sfr_lane.sv]
// One delay line: storage, absorption lowpass, feedback scaling and write back.
module sfr_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  sfr_pkg::lane_ctrl_type        ctrl,
   input  logic [sfr_pkg::ADDR_W-1:0]    wr_pos,
   input  logic [sfr_pkg::ADDR_W-1:0]    rd_pos,
   input  logic                          rd_ok,
   input  logic [sfr_pkg::COEF_W-1:0]    coef,
   input  logic [sfr_pkg::GAIN_W-1:0]    gain,
   input  sfr_pkg::sample_type           dry,
   input  sfr_pkg::had_type              mix,
   output sfr_pkg::sample_type           absorb
);
   import sfr_pkg::*;

   logic [SAMPLE_BITS-1:0]     rd_data;
   logic                       rok_ff;
   sample_type                 absorb_ff, absorb_in;
   sample_type                 line_rd;
   logic signed [SAMPLE_BITS:0] diff;
   logic signed [42:0]         abs_prod_ff, abs_prod_in;
   logic signed [42:0]         abs_rnd;
   logic signed [42:0]         scl_prod_ff, scl_prod_in;
   logic signed [42:0]         y_full;
   logic signed [43:0]         fb_prod_ff, fb_prod_in;
   logic signed [43:0]         fb_rnd;
   sample_type                 wr_val;

   sfr_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_DELAY)) u_ram (
      .clock   (clock),
      .wr_en   (ctrl.write),
      .wr_addr (wr_pos),
      .wr_data (wr_val),
      .rd_en   (ctrl.rd),
      .rd_addr (rd_pos),
      .rd_data (rd_data)
   );

   // never-written entries read as zero
   assign line_rd = rok_ff ? sample_type'(rd_data) : '0;
   assign diff    = (SAMPLE_BITS+1)'(line_rd) - (SAMPLE_BITS+1)'(absorb_ff);

   // lowpass: a += round(c * (r - a) / 2^16)
   assign abs_prod_in = 43'(diff) * 43'($signed({1'b0, coef}));
   assign abs_rnd     = (abs_prod_ff + 43'sd32768) >>> 16;
   assign absorb_in   = sat_sample(WIDE_W'(absorb_ff) + WIDE_W'(abs_rnd));

   // mix scaled by 1/sqrt(8), then feedback gain
   assign scl_prod_in = 43'(mix) * 43'sd23170;
   assign y_full      = (scl_prod_ff + 43'sd32768) >>> 16;
   assign fb_prod_in  = 44'(y_full) * 44'($signed({1'b0, gain}));
   assign fb_rnd      = (fb_prod_ff + 44'sd32768) >>> 16;
   assign wr_val      = sat_sample(WIDE_W'(dry) + WIDE_W'(fb_rnd));

   always_ff @(posedge clock) begin
      if (reset) begin
         absorb_ff <= '0;
      end else if (ctrl.abs_upd) begin
         absorb_ff <= absorb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd) rok_ff <= rd_ok;
      if (ctrl.abs_mul) abs_prod_ff <= abs_prod_in;
      if (ctrl.scale) scl_prod_ff <= scl_prod_in;
      if (ctrl.gain) fb_prod_ff <= fb_prod_in;
   end

   assign absorb = absorb_ff;
endmodule

[rtl/core/sfr_merge.sv]
// Merge stage: Hadamard mix by butterflies and the even/odd output sums.
module sfr_merge (
   input  logic                   clock,
   input  sfr_pkg::lane_ctrl_type ctrl,
   input  sfr_pkg::sample_type    absorb [sfr_pkg::LINES],
   output sfr_pkg::had_type       mix [sfr_pkg::LINES],
   output sfr_pkg::sum_type       sum_even,
   output sfr_pkg::sum_type       sum_odd
);
   import sfr_pkg::*;

   had_type v_ff [LINES];
   had_type v_in [LINES];
   sum_type sum_even_ff, sum_even_in;
   sum_type sum_odd_ff, sum_odd_in;

   // one butterfly rank per step, partner chosen by the mask bit
   always_comb begin
      logic [LINE_W-1:0] partner;
      sum_even_in = '0;
      sum_odd_in  = '0;
      for (int i = 0; i < LINES; i++) begin
         partner = LINE_W'(i) ^ ctrl.had_mask;
         if (ctrl.had_load) begin
            v_in[i] = HAD_W'(absorb[i]);
         end else if ((LINE_W'(i) & ctrl.had_mask) == '0) begin
            v_in[i] = v_ff[i] + v_ff[partner];
         end else begin
            v_in[i] = v_ff[partner] - v_ff[i];
         end
         if (i % 2 == 0) sum_even_in = sum_even_in + SUM_W'(absorb[i]);
         else sum_odd_in = sum_odd_in + SUM_W'(absorb[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.had_load || ctrl.had_step) v_ff <= v_in;
      if (ctrl.had_load) begin
         sum_even_ff <= sum_even_in;
         sum_odd_ff  <= sum_odd_in;
      end
   end

   assign mix      = v_ff;
   assign sum_even = sum_even_ff;
   assign sum_odd  = sum_odd_ff;
endmodule

[rtl/core/stereo_fdn_reverb_unit.sv]
// Stereo 8-line FDN reverb: register file, sequencer, lanes, merge and output.
//
// Channels: req_ch takes one stereo sample (in_left, in_right) per item;
// rsp_ch returns one result (out_left, out_right) per item; csr_ch writes a
// register by index (0 delays_low, 1 delays_high, 2 feedback_gain,
// 3 absorb_coeff, 4 wet_gain, 5 mono_input), is always ready, and is to be
// used only while the block is idle. Other indexes are ignored.
// The single sequencer steps the eight line lanes through read, lowpass,
// three butterfly ranks, scaling, gain and write back, and accepts the next
// item only once it is back in idle. With wet gain below 0.001 the result is
// zero, goes straight to the output step, and no line or lowpass state changes.
// The left and right networks see the same input and state, so one set of
// eight lanes serves both: even lines feed the left output, odd lines the right.
// Reset (synchronous) restores register defaults, clears the lowpass states,
// the write position and the fill flag; line entries not yet written read as
// zero, so no clearing pass is needed. A stalled receiver holds the result in
// the output register; a new item may be accepted meanwhile and waits in the output step.
module stereo_fdn_reverb_unit (
   input logic      clock,
   input logic      reset,
   sfr_req_if.sink  req_ch,
   sfr_rsp_if.source rsp_ch,
   sfr_csr_if.sink  csr_ch
);
   import sfr_pkg::*;

   // configuration registers
   logic [CSR_DATA_W-1:0] dly_lo_ff, dly_hi_ff;
   logic [GAIN_W-1:0]     fb_ff;
   logic [COEF_W-1:0]     coef_ff;
   logic [COEF_W-1:0]     wet_ff;
   logic                  mono_ff;

   logic [GAIN_W-1:0]     gain_c;
   logic [COEF_W-1:0]     coef_c;
   logic [COEF_W-1:0]     wet_c;
   logic                  wet_low;

   fsm_type               state_ff, state_in;
   lane_ctrl_type         ctrl;
   logic                  req_acc;
   logic                  bypass_ff, bypass_in;
   sample_type            dry_ff;
   logic signed [SAMPLE_BITS:0] dry_sum;
   logic [ADDR_W-1:0]     wp_ff;
   logic                  full_ff;

   logic [ADDR_W-1:0]     rd_pos [LINES];
   logic                  rd_ok [LINES];
   sample_type            absorb [LINES];
   had_type               mix [LINES];
   sum_type               sum_even, sum_odd;

   logic signed [43:0]    out_l_prod_ff, out_r_prod_ff;
   logic signed [43:0]    out_l_rnd, out_r_rnd;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_load;
   sample_type            out_l_ff, out_r_ff;

   // register writes
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dly_lo_ff <= '0;
         dly_hi_ff <= '0;
         fb_ff     <= '0;
         coef_ff   <= COEF_W'(UNITY_Q16);
         wet_ff    <= COEF_W'(UNITY_Q16);
         mono_ff   <= 1'b0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_DELAYS_LOW:  dly_lo_ff <= csr_ch.data;
            CSR_DELAYS_HIGH: dly_hi_ff <= csr_ch.data;
            CSR_FEEDBACK:    fb_ff     <= csr_ch.data[GAIN_W-1:0];
            CSR_ABSORB:      coef_ff   <= csr_ch.data[COEF_W-1:0];
            CSR_WET:         wet_ff    <= csr_ch.data[COEF_W-1:0];
            CSR_MONO:        mono_ff   <= csr_ch.data[0];
            default: ;
         endcase
      end
   end

   // clamped gains
   assign gain_c  = (fb_ff > GAIN_W'(FB_MAX)) ? GAIN_W'(FB_MAX) : fb_ff;
   assign coef_c  = (coef_ff < COEF_W'(ABS_MIN)) ? COEF_W'(ABS_MIN) :
                    (coef_ff > COEF_W'(UNITY_Q16)) ? COEF_W'(UNITY_Q16) : coef_ff;
   assign wet_c   = (wet_ff > COEF_W'(UNITY_Q16)) ? COEF_W'(UNITY_Q16) : wet_ff;
   assign wet_low = wet_c < COEF_W'(WET_MIN);

   // dry value, floor of the mean or left alone
   assign dry_sum = (SAMPLE_BITS+1)'(req_ch.in_left) + (SAMPLE_BITS+1)'(req_ch.in_right);

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (req_acc) dry_ff <= mono_ff ? req_ch.in_left : SAMPLE_BITS'(dry_sum >>> 1);
   end

   // read positions per line, delay clamped to 1..MAX_DELAY
   always_comb begin
      logic [DLY_W-1:0]  d_raw;
      logic [ADDR_W:0]   d_c;
      for (int i = 0; i < LINES; i++) begin
         if (i < LINES / 2) d_raw = dly_lo_ff[DLY_W*i +: DLY_W];
         else d_raw = dly_hi_ff[DLY_W*(i-LINES/2) +: DLY_W];
         if (d_raw == '0) d_c = (ADDR_W+1)'(1);
         else if (32'(d_raw) > MAX_DELAY) d_c = (ADDR_W+1)'(MAX_DELAY);
         else d_c = (ADDR_W+1)'(d_raw);
         rd_pos[i] = wp_ff - d_c[ADDR_W-1:0];
         rd_ok[i]  = full_ff || (rd_pos[i] < wp_ff);
      end
   end

   // sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bypass_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bypass_ff    <= bypass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and strobes
   always_comb begin
      state_in  = state_ff;
      bypass_in = bypass_ff;
      ctrl      = '0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               bypass_in = wet_low;
               state_in  = wet_low ? ST_OUTP : ST_RD;
            end
         end
         ST_RD: begin
            ctrl.rd  = 1'b1;
            state_in = ST_ABS_MUL;
         end
         ST_ABS_MUL: begin
            ctrl.abs_mul = 1'b1;
            state_in     = ST_ABS_UPD;
         end
         ST_ABS_UPD: begin
            ctrl.abs_upd = 1'b1;
            state_in     = ST_HLOAD;
         end
         ST_HLOAD: begin
            ctrl.had_load = 1'b1;
            state_in      = ST_HB0;
         end
         ST_HB0: begin
            ctrl.had_step = 1'b1;
            ctrl.had_mask = LINE_W'(1);
            state_in      = ST_HB1;
         end
         ST_HB1: begin
            ctrl.had_step = 1'b1;
            ctrl.had_mask = LINE_W'(2);
            state_in      = ST_HB2;
         end
         ST_HB2: begin
            ctrl.had_step = 1'b1;
            ctrl.had_mask = LINE_W'(4);
            state_in      = ST_SCALE;
         end
         ST_SCALE: begin
            ctrl.scale = 1'b1;
            state_in   = ST_GAIN;
         end
         ST_GAIN: begin
            ctrl.gain = 1'b1;
            state_in  = ST_WRITE;
         end
         ST_WRITE: begin
            ctrl.write = 1'b1;
            state_in   = ST_OUTP;
         end
         ST_OUTP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // shared write position and fill flag
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         full_ff <= 1'b0;
      end else if (ctrl.write) begin
         wp_ff <= wp_ff + ADDR_W'(1);
         if (wp_ff == ADDR_W'(MAX_DELAY - 1)) full_ff <= 1'b1;
      end
   end

   // line lanes
   for (genvar g = 0; g < LINES; g++) begin : g_lane
      sfr_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (ctrl),
         .wr_pos (wp_ff),
         .rd_pos (rd_pos[g]),
         .rd_ok  (rd_ok[g]),
         .coef   (coef_c),
         .gain   (gain_c),
         .dry    (dry_ff),
         .mix    (mix[g]),
         .absorb (absorb[g])
      );
   end

   sfr_merge u_merge (
      .clock    (clock),
      .ctrl     (ctrl),
      .absorb   (absorb),
      .mix      (mix),
      .sum_even (sum_even),
      .sum_odd  (sum_odd)
   );

   // wet scaling of the output sums
   always_ff @(posedge clock) begin
      if (ctrl.scale) begin
         out_l_prod_ff <= 44'(sum_even) * 44'($signed({1'b0, wet_c}));
         out_r_prod_ff <= 44'(sum_odd) * 44'($signed({1'b0, wet_c}));
      end
   end

   assign out_l_rnd = (out_l_prod_ff + 44'sd131072) >>> 18;
   assign out_r_rnd = (out_r_prod_ff + 44'sd131072) >>> 18;

   // output register
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         out_l_ff <= bypass_ff ? '0 : sat_sample(WIDE_W'(out_l_rnd));
         out_r_ff <= bypass_ff ? '0 : sat_sample(WIDE_W'(out_r_rnd));
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_left  = out_l_ff;
   assign rsp_ch.out_right = out_r_ff;

`ifndef SYNTHESIS
   // write position moves only on the write-back step
   a_wp_moves_on_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_WRITE) |=> $stable(wp_ff))
      else $error("write position moved outside write-back");

   // once every entry has been written the fill flag stays set
   a_full_sticks: assert property (@(posedge clock) disable iff (reset)
      full_ff |=> full_ff)
      else $error("fill flag dropped");

   // an accepted item always leaves the idle state
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff != ST_IDLE))
      else $error("accepted item not started");

   // a silent item touches no line state
   a_bypass_no_write: assert property (@(posedge clock) disable iff (reset)
      bypass_ff |-> !ctrl.write)
      else $error("silent item wrote a line");
`endif
endmodule
